@@ rtl/tgsa_pkg.sv @@
// ----------------------------------------------------------------------------
// tgsa_pkg
// shared constants, codes and controller/datapath interface types for the
// table grid slot assigner
// ----------------------------------------------------------------------------
package tgsa_pkg;

  // grid bounds
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 256;

  // internal widths derived from the bounds
  localparam int COL_W     = $clog2(MAX_COLUMNS + 1);
  localparam int COL_IDX_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W     = $clog2(MAX_ROWS + 1);
  localparam int ROW_IDX_W = $clog2(MAX_ROWS);

  // fixed field widths
  localparam int ACTION_W    = 2;
  localparam int CSPAN_W     = 7;
  localparam int RSPAN_W     = 9;
  localparam int SLOT_COL_W  = 6;
  localparam int SLOT_ROW_W  = 8;
  localparam int COLS_USED_W = 7;
  localparam int ROWS_USED_W = 9;

  // free-slot scan: columns looked at per cycle
  localparam int SCAN_W     = 8;
  localparam int SCAN_LOG   = $clog2(SCAN_W);
  localparam int SCAN_IDX_W = COL_W + SCAN_LOG;

  // compare widths for span clipping
  localparam int CMP_CW = (CSPAN_W > COL_W) ? CSPAN_W : COL_W;
  localparam int CMP_RW = (RSPAN_W > ROW_W) ? RSPAN_W : ROW_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_BEGIN_ROW  = 2'd0,
    ACT_PLACE_CELL = 2'd1,
    ACT_END_ROW    = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CLIP,
    S_MREAD,
    S_MWRITE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic latch;        // capture input word
    logic simple;       // apply begin row, end row or clear
    logic drop;         // cell dropped, cursor row past the grid
    logic col_exhaust;  // cell dropped, no free column left
    logic rd_cursor;    // read occupancy row at cursor, start scan
    logic scan;         // advance free-slot scan
    logic clip;         // clip spans, update counts, build mask
    logic rd_mark;      // read row being marked
    logic wr_mark;      // write marked row back
    logic load_out;     // load output register
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    row_full;
    logic    scan_found;
    logic    scan_none;
    logic    mark_last;
  } status_t;

endpackage

@@ rtl/table_grid_slot_assigner_core.sv @@
// ----------------------------------------------------------------------------
// table_grid_slot_assigner_core
// assigns grid slots to table cells: begin row, place cell, end row and
// clear table words in, one result word out per input word
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | action, col_span, row_span
//  out     | out_valid / out_ready| placed, slot_column, slot_row,
//          |                      | columns_used, rows_used, overflow
//
//  one word at a time; in_ready is high while the sequencer is idle
//  begin row, end row, clear table: accept, decode, then emit the result
//  place cell: accept, decode with a cursor row read, scan in 8-column chunks
//    from the cursor (1 to 8 chunks), clip, then each clipped spanned row as a
//    read then a write on the single occupancy memory port, then emit
//  a cell dropped for lack of room goes to emit without clip or marking
//  reset clears all occupancy valid bits at once, no clearing pass
//  a waiting result holds the sequencer in its last state until taken; the
//  output register lets the next word in as soon as the result is loaded
//
module table_grid_slot_assigner_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tgsa_pkg::ACTION_W-1:0]        action,
  input  logic [tgsa_pkg::CSPAN_W-1:0]         col_span,
  input  logic [tgsa_pkg::RSPAN_W-1:0]         row_span,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 placed,
  output logic [tgsa_pkg::SLOT_COL_W-1:0]      slot_column,
  output logic [tgsa_pkg::SLOT_ROW_W-1:0]      slot_row,
  output logic [tgsa_pkg::COLS_USED_W-1:0]     columns_used,
  output logic [tgsa_pkg::ROWS_USED_W-1:0]     rows_used,
  output logic                                 overflow
);
  import tgsa_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t sts;

  // sequencer: handshakes and per-word command sequence
  tgsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // occupancy memory, cursor, counts, scan, clip, output register
  tgsa_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .action       (action),
    .col_span     (col_span),
    .row_span     (row_span),
    .placed       (placed),
    .slot_column  (slot_column),
    .slot_row     (slot_row),
    .columns_used (columns_used),
    .rows_used    (rows_used),
    .overflow     (overflow)
  );

`ifndef ASSERT_OFF
  // a placed cell lies inside the reported grid width
  a_col_in_grid: assert property (@(posedge clk) disable iff (rst)
    out_valid && placed |-> ROWS_USED_W'(slot_column) < ROWS_USED_W'(columns_used))
    else $error("placed column outside grid width");

  // a placed cell lies inside the reported grid height
  a_row_in_grid: assert property (@(posedge clk) disable iff (rst)
    out_valid && placed |-> ROWS_USED_W'(slot_row) < rows_used)
    else $error("placed row outside grid height");

  // results without a placement carry a zero slot
  a_zero_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !placed |-> slot_column == '0 && slot_row == '0)
    else $error("nonzero slot on a result without placement");

  // one word at a time: no accept right after an accept
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in progress");
`endif

endmodule

@@ rtl/tgsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// tgsa_ctrl
// sequencer for the slot assigner: handshakes and command issue per word
// ----------------------------------------------------------------------------
module tgsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tgsa_pkg::status_t sts,
  output tgsa_pkg::cmd_t    cmd
);
  import tgsa_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.act == ACT_PLACE_CELL) begin
          if (sts.row_full) begin
            cmd.drop   = 1'b1;
            state_next = S_EMIT;
          end else begin
            cmd.rd_cursor = 1'b1;
            state_next    = S_SCAN;
          end
        end else begin
          cmd.simple = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_SCAN: begin
        if (sts.scan_found) begin
          cmd.scan   = 1'b1;
          state_next = S_CLIP;
        end else if (sts.scan_none) begin
          cmd.col_exhaust = 1'b1;
          state_next      = S_EMIT;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_CLIP: begin
        cmd.clip   = 1'b1;
        state_next = S_MREAD;
      end
      S_MREAD: begin
        cmd.rd_mark = 1'b1;
        state_next  = S_MWRITE;
      end
      S_MWRITE: begin
        cmd.wr_mark = 1'b1;
        state_next  = sts.mark_last ? S_EMIT : S_MREAD;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

@@ rtl/tgsa_dpath.sv @@
// ----------------------------------------------------------------------------
// tgsa_dpath
// occupancy memory, cursor and grid counters, free-slot scan, span clipping
// and the output register
// ----------------------------------------------------------------------------
module tgsa_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tgsa_pkg::cmd_t                       cmd,
  output tgsa_pkg::status_t                    sts,
  input  logic [tgsa_pkg::ACTION_W-1:0]        action,
  input  logic [tgsa_pkg::CSPAN_W-1:0]         col_span,
  input  logic [tgsa_pkg::RSPAN_W-1:0]         row_span,
  output logic                                 placed,
  output logic [tgsa_pkg::SLOT_COL_W-1:0]      slot_column,
  output logic [tgsa_pkg::SLOT_ROW_W-1:0]      slot_row,
  output logic [tgsa_pkg::COLS_USED_W-1:0]     columns_used,
  output logic [tgsa_pkg::ROWS_USED_W-1:0]     rows_used,
  output logic                                 overflow
);
  import tgsa_pkg::*;

  // occupancy store, one word per grid row
  logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]    row_valid;
  logic [MAX_COLUMNS-1:0] rdata;
  logic                   rd_vld;
  logic [MAX_COLUMNS-1:0] row_word;
  logic                   rd_en;
  logic [ROW_IDX_W-1:0]   rd_addr;

  // control state
  logic [COL_W-1:0] cursor_column;
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] grid_width;
  logic [ROW_W-1:0] grid_height;

  // per word working registers
  action_t              act_q;
  logic [CSPAN_W-1:0]   cspan_q;
  logic [RSPAN_W-1:0]   rspan_q;
  logic [COL_W-1:0]     scan_col;
  logic [COL_W-1:0]     col_sel;
  logic [MAX_COLUMNS-1:0] mark_mask;
  logic [ROW_W-1:0]     mark_row;
  logic [ROW_W-1:0]     row_end;
  logic                 res_placed;
  logic [COL_W-1:0]     res_col;
  logic [ROW_W-1:0]     res_row;
  logic                 res_ovf;

  // scan and clip logic
  logic [SCAN_IDX_W-1:0] scan_base;
  logic [SCAN_IDX_W-1:0] scan_nxt;
  logic                  scan_found;
  logic [COL_W-1:0]      found_col;
  logic                  row_full;
  logic [CSPAN_W-1:0]    cs_raw;
  logic [RSPAN_W-1:0]    rs_raw;
  logic [COL_W-1:0]      col_avail;
  logic [ROW_W-1:0]      row_avail;
  logic                  cs_over;
  logic                  rs_over;
  logic [COL_W-1:0]      cs_eff;
  logic [ROW_W-1:0]      rs_eff;
  logic [COL_W-1:0]      col_end;
  logic [ROW_W-1:0]      row_end_c;
  logic [MAX_COLUMNS-1:0] mask_c;

  assign row_full = (cursor_row >= ROW_W'(MAX_ROWS));
  assign row_word = rd_vld ? rdata : '0;

  // memory port
  assign rd_en   = cmd.rd_cursor | cmd.rd_mark;
  assign rd_addr = cmd.rd_cursor ? cursor_row[ROW_IDX_W-1:0] : mark_row[ROW_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata  <= mem[rd_addr];
      rd_vld <= row_valid[rd_addr];
    end
    if (cmd.wr_mark) begin
      mem[mark_row[ROW_IDX_W-1:0]] <= row_word | mark_mask;
    end
  end

  // one chunk of the free-slot scan, lowest free column wins
  always_comb begin
    logic [SCAN_IDX_W-1:0] idx;
    scan_base  = SCAN_IDX_W'(scan_col) & ~SCAN_IDX_W'(SCAN_W - 1);
    scan_nxt   = scan_base + SCAN_IDX_W'(SCAN_W);
    scan_found = 1'b0;
    found_col  = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      idx = scan_base + SCAN_IDX_W'(i);
      if (idx >= SCAN_IDX_W'(scan_col) && idx < SCAN_IDX_W'(MAX_COLUMNS) &&
          !row_word[idx[COL_IDX_W-1:0]]) begin
        scan_found = 1'b1;
        found_col  = COL_W'(idx);
      end
    end
  end

  // span clipping and mask
  always_comb begin
    cs_raw    = (cspan_q == '0) ? CSPAN_W'(1) : cspan_q;
    rs_raw    = (rspan_q == '0) ? RSPAN_W'(1) : rspan_q;
    col_avail = COL_W'(MAX_COLUMNS) - col_sel;
    row_avail = ROW_W'(MAX_ROWS) - cursor_row;
    cs_over   = CMP_CW'(cs_raw) > CMP_CW'(col_avail);
    rs_over   = CMP_RW'(rs_raw) > CMP_RW'(row_avail);
    cs_eff    = cs_over ? col_avail : COL_W'(cs_raw);
    rs_eff    = rs_over ? row_avail : ROW_W'(rs_raw);
    col_end   = col_sel + cs_eff;
    row_end_c = cursor_row + rs_eff;
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      mask_c[j] = (COL_W'(j) >= col_sel) && (COL_W'(j) < col_end);
    end
  end

  always_comb begin
    sts            = '0;
    sts.act        = act_q;
    sts.row_full   = row_full;
    sts.scan_found = scan_found;
    sts.scan_none  = !scan_found && (scan_nxt >= SCAN_IDX_W'(MAX_COLUMNS));
    sts.mark_last  = (mark_row + ROW_W'(1)) == row_end;
  end

  // cursor, counts and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
      grid_width    <= '0;
      grid_height   <= '0;
      row_valid     <= '0;
    end else if (cmd.simple) begin
      case (act_q)
        ACT_BEGIN_ROW: begin
          cursor_column <= '0;
          if (!row_full && grid_height == cursor_row) begin
            grid_height <= grid_height + ROW_W'(1);
          end
        end
        ACT_END_ROW: begin
          cursor_column <= '0;
          if (!row_full) begin
            cursor_row <= cursor_row + ROW_W'(1);
          end
        end
        ACT_CLEAR: begin
          cursor_column <= '0;
          cursor_row    <= '0;
          grid_width    <= '0;
          grid_height   <= '0;
          row_valid     <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.col_exhaust) begin
      cursor_column <= COL_W'(MAX_COLUMNS);
    end else if (cmd.clip) begin
      cursor_column <= col_end;
      if (grid_width < col_end) begin
        grid_width <= col_end;
      end
      if (grid_height < row_end_c) begin
        grid_height <= row_end_c;
      end
    end else if (cmd.wr_mark) begin
      row_valid[mark_row[ROW_IDX_W-1:0]] <= 1'b1;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q   <= action_t'(action);
      cspan_q <= col_span;
      rspan_q <= row_span;
    end
    if (cmd.rd_cursor) begin
      scan_col <= cursor_column;
    end
    if (cmd.scan) begin
      if (scan_found) begin
        col_sel <= found_col;
      end else begin
        scan_col <= COL_W'(scan_nxt);
      end
    end
    if (cmd.simple || cmd.drop || cmd.col_exhaust) begin
      res_placed <= 1'b0;
      res_col    <= '0;
      res_row    <= '0;
      res_ovf    <= cmd.drop || cmd.col_exhaust || (act_q == ACT_BEGIN_ROW && row_full);
    end
    if (cmd.clip) begin
      mark_mask  <= mask_c;
      mark_row   <= cursor_row;
      row_end    <= row_end_c;
      res_placed <= 1'b1;
      res_col    <= col_sel;
      res_row    <= cursor_row;
      res_ovf    <= cs_over || rs_over;
    end
    if (cmd.wr_mark) begin
      mark_row <= mark_row + ROW_W'(1);
    end
    if (cmd.load_out) begin
      placed       <= res_placed;
      slot_column  <= SLOT_COL_W'(res_col);
      slot_row     <= SLOT_ROW_W'(res_row);
      columns_used <= COLS_USED_W'(grid_width);
      rows_used    <= ROWS_USED_W'(grid_height);
      overflow     <= res_ovf;
    end
  end

endmodule

@@ bench/tb_table_grid_slot_assigner_core.sv @@
// ----------------------------------------------------------------------------
// tb_table_grid_slot_assigner_core
// self-checking bench for the table grid slot assigner: directed corner
// words, then randomized tables, noise and a run off the bottom of the grid,
// with every result word predicted and compared field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_table_grid_slot_assigner_core;
  import tgsa_pkg::*;

  localparam int N_WORDS   = 1500;  // rough size of the random part
  localparam int HOLD_AT   = 300;   // sink goes quiet around this word
  localparam int HOLD_LEN  = 300;   // cycles of sink hold-off
  localparam int PAUSE_AT  = 700;   // source stops and lets the block drain
  localparam int STEADY_LO = 900;   // no idling on either side in this span
  localparam int STEADY_HI = 1150;
  localparam int TAIL      = 600;   // long enough for the tallest cell: full scan, every grid row marked

  // one result word as seen on the output ports
  typedef struct packed {
    logic                   placed;
    logic [SLOT_COL_W-1:0]  slot_column;
    logic [SLOT_ROW_W-1:0]  slot_row;
    logic [COLS_USED_W-1:0] columns_used;
    logic [ROWS_USED_W-1:0] rows_used;
    logic                   overflow;
  } grid_result_t;

  // tracks the grid the block should be building and the results it owes
  class slot_scoreboard;
    bit [MAX_COLUMNS-1:0] occ [MAX_ROWS];
    int unsigned          cur_col, cur_row, grid_w, grid_h;
    grid_result_t         expected_q [$];
    int                   errors, results_seen, cells_placed, cells_dropped;
    int                   overflows, deepest_row;

    function void clear_grid();
      foreach (occ[i]) occ[i] = '0;
      cur_col = 0;
      cur_row = 0;
      grid_w  = 0;
      grid_h  = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // apply one accepted word to the grid and queue the result it owes
    function void note_word(action_t act, bit [CSPAN_W-1:0] cs_in,
                            bit [RSPAN_W-1:0] rs_in);
      grid_result_t         r;
      int unsigned          cs, rs, col, row, rw;
      bit [MAX_COLUMNS-1:0] mask;
      r = '0;
      case (act)
        ACT_BEGIN_ROW: begin
          cur_col = 0;
          if (cur_row >= MAX_ROWS) r.overflow = 1'b1;
          else if (grid_h == cur_row) grid_h++;
        end
        ACT_END_ROW: begin
          if (cur_row < MAX_ROWS) cur_row++;
          cur_col = 0;
        end
        ACT_CLEAR: begin
          clear_grid();
        end
        default: begin
          if (cur_row >= MAX_ROWS) begin
            r.overflow = 1'b1;
          end else begin
            // skip slots held by row spans from above, from the cursor to the first free column
            while (cur_col < MAX_COLUMNS && occ[cur_row][cur_col]) cur_col++;
            if (cur_col >= MAX_COLUMNS) begin
              r.overflow = 1'b1;
            end else begin
              cs = (cs_in == 0) ? 1 : 32'(cs_in);
              rs = (rs_in == 0) ? 1 : 32'(rs_in);
              if (cs > MAX_COLUMNS - cur_col) begin
                cs = MAX_COLUMNS - cur_col;
                r.overflow = 1'b1;
              end
              if (rs > MAX_ROWS - cur_row) begin
                rs = MAX_ROWS - cur_row;
                r.overflow = 1'b1;
              end
              col  = cur_col;
              row  = cur_row;
              mask = (cs >= MAX_COLUMNS) ? '1 : ((MAX_COLUMNS'(1) << cs) - 1);
              mask = mask << col;
              for (rw = row; rw < row + rs; rw++) occ[rw] |= mask;
              if (grid_w < col + cs) grid_w = col + cs;
              if (grid_h < row + rs) grid_h = row + rs;
              cur_col       = col + cs;
              r.placed      = 1'b1;
              r.slot_column = col[SLOT_COL_W-1:0];
              r.slot_row    = row[SLOT_ROW_W-1:0];
              cells_placed++;
            end
          end
          if (!r.placed) cells_dropped++;
        end
      endcase
      r.columns_used = grid_w[COLS_USED_W-1:0];
      r.rows_used    = grid_h[ROWS_USED_W-1:0];
      if (r.overflow) overflows++;
      if (cur_row > deepest_row) deepest_row = cur_row;
      expected_q.push_back(r);
    endfunction

    function void check_result(grid_result_t got);
      grid_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result word with nothing expected: placed %0d col %0d row %0d",
               got.placed, got.slot_column, got.slot_row);
        return;
      end
      want = expected_q.pop_front();
      if (got.placed !== want.placed) begin
        errors++;
        $error("placed: expected %0d, got %0d", want.placed, got.placed);
      end
      if (got.slot_column !== want.slot_column) begin
        errors++;
        $error("slot_column: expected %0d, got %0d", want.slot_column, got.slot_column);
      end
      if (got.slot_row !== want.slot_row) begin
        errors++;
        $error("slot_row: expected %0d, got %0d", want.slot_row, got.slot_row);
      end
      if (got.columns_used !== want.columns_used) begin
        errors++;
        $error("columns_used: expected %0d, got %0d", want.columns_used,
               got.columns_used);
      end
      if (got.rows_used !== want.rows_used) begin
        errors++;
        $error("rows_used: expected %0d, got %0d", want.rows_used, got.rows_used);
      end
      if (got.overflow !== want.overflow) begin
        errors++;
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [ACTION_W-1:0]    action;
  logic [CSPAN_W-1:0]     col_span;
  logic [RSPAN_W-1:0]     row_span;
  logic                   out_valid;
  logic                   out_ready;
  logic                   placed;
  logic [SLOT_COL_W-1:0]  slot_column;
  logic [SLOT_ROW_W-1:0]  slot_row;
  logic [COLS_USED_W-1:0] columns_used;
  logic [ROWS_USED_W-1:0] rows_used;
  logic                   overflow;

  slot_scoreboard sb;
  int             sent_count;
  bit             steady;     // both sides run flat out
  bit             want_hold;  // ask the sink for a long hold-off

  table_grid_slot_assigner_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .col_span     (col_span),
    .row_span     (row_span),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .placed       (placed),
    .slot_column  (slot_column),
    .slot_row     (slot_row),
    .columns_used (columns_used),
    .rows_used    (rows_used),
    .overflow     (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // both handshakes are observed here, at the edge, before any update lands
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_word(action_t'(action), col_span, row_span);
      if (out_valid && out_ready)
        sb.check_result({placed, slot_column, slot_row, columns_used,
                         rows_used, overflow});
    end
  end

  // sink: random back-pressure, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 29);
      end
    end
  end

  // stop offering until every owed result word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // offer one word and hold it until the block takes it
  task automatic send_word(action_t a, bit [CSPAN_W-1:0] cs, bit [RSPAN_W-1:0] rs);
    if (sent_count == HOLD_AT) want_hold = 1'b1;
    if (sent_count == PAUSE_AT) wait_drained();
    steady = (sent_count >= STEADY_LO && sent_count < STEADY_HI);
    while (!steady && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= a;
    col_span <= cs;
    row_span <= rs;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // mostly narrow cells, now and then wide or out of range
  function automatic bit [CSPAN_W-1:0] pick_col_span();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return CSPAN_W'($urandom_range(4, 1));
    if (p < 85) return CSPAN_W'($urandom_range(16, 1));
    if (p < 95) return CSPAN_W'($urandom_range(MAX_COLUMNS, 1));
    return CSPAN_W'($urandom_range(127, 0));
  endfunction

  // tall cells cost a memory read and a write per row, so keep most of them short
  function automatic bit [RSPAN_W-1:0] pick_row_span();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 75) return RSPAN_W'($urandom_range(3, 1));
    if (p < 95) return RSPAN_W'($urandom_range(8, 1));
    return RSPAN_W'($urandom_range(511, 0));
  endfunction

  // a well-formed table with random content, begin or end row now and then lost
  task automatic random_table();
    int rows, cells;
    if ($urandom_range(99) < 70)
      send_word(ACT_CLEAR, CSPAN_W'($urandom), RSPAN_W'($urandom));
    rows = $urandom_range(8, 1);
    repeat (rows) begin
      if ($urandom_range(99) < 92)
        send_word(ACT_BEGIN_ROW, CSPAN_W'($urandom), RSPAN_W'($urandom));
      cells = $urandom_range(10, 1);
      repeat (cells) send_word(ACT_PLACE_CELL, pick_col_span(), pick_row_span());
      if ($urandom_range(99) < 92)
        send_word(ACT_END_ROW, CSPAN_W'($urandom), RSPAN_W'($urandom));
    end
  endtask

  // walk the cursor to the last row and past it
  task automatic bottom_run();
    send_word(ACT_CLEAR, CSPAN_W'($urandom), RSPAN_W'($urandom));
    send_word(ACT_BEGIN_ROW, CSPAN_W'($urandom), RSPAN_W'($urandom));
    send_word(ACT_PLACE_CELL, 7'd5, 9'd300);  // column strip down the whole grid
    repeat (MAX_ROWS - 1) send_word(ACT_END_ROW, CSPAN_W'($urandom), RSPAN_W'($urandom));
    send_word(ACT_BEGIN_ROW, CSPAN_W'($urandom), RSPAN_W'($urandom));
    send_word(ACT_PLACE_CELL, 7'd2, 9'd4);    // skips the strip, rows clipped
    send_word(ACT_END_ROW, CSPAN_W'($urandom), RSPAN_W'($urandom));
    // cursor below the grid
    send_word(ACT_BEGIN_ROW, CSPAN_W'($urandom), RSPAN_W'($urandom));
    send_word(ACT_PLACE_CELL, 7'd1, 9'd1);         // no row to land in
    // cursor row saturates
    send_word(ACT_END_ROW, CSPAN_W'($urandom), RSPAN_W'($urandom));
    send_word(ACT_CLEAR, CSPAN_W'($urandom), RSPAN_W'($urandom));
  endtask

  initial begin
    int table_no, p, n;
    sb = new();
    sb.clear_grid();
    sent_count = 0;
    steady     = 1'b0;
    want_hold  = 1'b0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    action   <= ACT_BEGIN_ROW;
    col_span <= '0;
    row_span <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_word(ACT_CLEAR, 7'd127, 9'd511);
    send_word(ACT_BEGIN_ROW, 7'd0, 9'd0);
    send_word(ACT_PLACE_CELL, 7'd0, 9'd0);     // zero spans act as one
    send_word(ACT_PLACE_CELL, 7'd1, 9'd3);     // reaches two rows down
    send_word(ACT_PLACE_CELL, 7'd127, 9'd1);   // columns clipped, row now full
    send_word(ACT_PLACE_CELL, 7'd2, 9'd1);     // no free column, dropped
    send_word(ACT_END_ROW, 7'd127, 9'd511);
    send_word(ACT_BEGIN_ROW, 7'd127, 9'd511);
    send_word(ACT_PLACE_CELL, 7'd1, 9'd1);     // first column free
    send_word(ACT_PLACE_CELL, 7'd64, 9'd511);  // skips mid-row, both spans clipped
    send_word(ACT_END_ROW, 7'd0, 9'd0);
    send_word(ACT_BEGIN_ROW, 7'd0, 9'd0);
    send_word(ACT_PLACE_CELL, 7'd1, 9'd1);
    send_word(ACT_PLACE_CELL, 7'd1, 9'd1);     // rest of row covered from above
    send_word(ACT_CLEAR, 7'd0, 9'd0);
    send_word(ACT_BEGIN_ROW, 7'd0, 9'd0);
    send_word(ACT_PLACE_CELL, 7'd64, 9'd256);  // exactly fills the grid
    send_word(ACT_END_ROW, 7'd0, 9'd0);
    send_word(ACT_BEGIN_ROW, 7'd0, 9'd0);      // grid already taller
    send_word(ACT_PLACE_CELL, 7'd1, 9'd1);     // grid full, dropped
    send_word(ACT_CLEAR, 7'd0, 9'd0);
    send_word(ACT_END_ROW, 7'd0, 9'd0);        // end row with no begin
    send_word(ACT_BEGIN_ROW, 7'd0, 9'd0);
    send_word(ACT_BEGIN_ROW, 7'd0, 9'd0);      // second begin does not grow
    send_word(ACT_PLACE_CELL, 7'd126, 9'd510);

    // random part: mostly tables, some noise, an occasional bottom run
    table_no = 0;
    while (sent_count < N_WORDS) begin
      p = $urandom_range(99);
      if (table_no == 2 || p >= 98) begin
        bottom_run();
      end else if (p < 82) begin
        random_table();
      end else begin
        n = $urandom_range(10, 1);
        repeat (n) send_word(action_t'($urandom_range(3, 0)), CSPAN_W'($urandom),
                             RSPAN_W'($urandom));
      end
      table_no++;
    end

    wait_drained();
    repeat (TAIL) @(posedge clk);
    $display("covered %0d words in %0d tables: %0d cells placed, %0d dropped",
             sent_count, table_no, sb.cells_placed, sb.cells_dropped);
    $display("%0d overflow results, cursor reached row %0d, %0d mismatches",
             sb.overflows, sb.deepest_row, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // the limit is about ten times the slowest correct run, even if every word
  // were a full-height cell waiting out both sides' stalls
  initial begin
    #(64'd100_000_000);
    $display("timeout with %0d result words still owed", sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tgsa_pkg.sv
rtl/tgsa_ctrl.sv
rtl/tgsa_dpath.sv
rtl/table_grid_slot_assigner_core.sv
bench/tb_table_grid_slot_assigner_core.sv
